@@ rtl/core/advd_pkg.sv @@
// Shared constants, codes and types of the adaptive delta video decoder.
// Used by advd_div, advd_seq and adaptive_delta_video_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package advd_pkg;

   // Frame limits and last-pixel store size
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_BLOCK   = 64;
   localparam int STORE_DEPTH = 16384;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Configuration register widths
   localparam int DIM_W     = 11;
   localparam int BLK_W     = 7;
   localparam int STEP_W    = 8;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 3;

   // Counter widths
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int BC_W  = $clog2(MAX_WIDTH);
   localparam int PIB_W = $clog2(MAX_BLOCK);
   localparam int LBC_W = 4;
   localparam int CI_W  = 2;
   localparam int RUN_W = 6;

   // Pixel data
   localparam int NUM_CH  = 3;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 24;
   localparam int INDEX_W = 20;

   // Shared multiplier
   localparam int MUL_W  = 12;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [CH_W-1:0]  LEVEL_MAX     = 8'd255;
   localparam logic [RUN_W-1:0] RUN_MAX       = 6'd63;
   localparam logic [2:0]       LEVEL_TOP_BIT = 3'd7;
   localparam logic [CI_W-1:0]  LAST_CH       = 2'd2;
   localparam logic [1:0]       NCH_GRAY      = 2'd1;
   localparam logic [1:0]       NCH_RGB       = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_STEP_BASE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_STEP_QUAD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_STEP_BASE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_STEP_QUAD   = 3'd7;

   // Register reset values
   localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 11'd320;
   localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 11'd200;
   localparam logic [BLK_W-1:0]  BLOCK_WIDTH_RST  = 7'd8;
   localparam logic [STEP_W-1:0] STEP_RST         = 8'd1;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LEVEL,
      PH_PIXEL
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_RDW,
      ST_SQ,
      ST_STEP,
      ST_PIX,
      ST_IDX,
      ST_WR,
      ST_EMIT
   } seq_state_type;

   // Clamped configuration as the decoder sees it
   typedef struct packed {
      logic              color_mode;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [BLK_W-1:0]  block;
      logic [DIM_W-1:0]  blocks_per_row;
      logic [STEP_W-1:0] down_base;
      logic [STEP_W-1:0] down_quad;
      logic [STEP_W-1:0] up_base;
      logic [STEP_W-1:0] up_quad;
   } cfg_type;

   typedef struct packed {
      logic               pixel_valid;
      logic [INDEX_W-1:0] pixel_index;
      logic [PIX_W-1:0]   pixel_value;
      logic               frame_done;
   } res_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] waddr;
      logic [PIX_W-1:0]    wdata;
      logic                re;
      logic [STORE_AW-1:0] raddr;
   } store_req_type;

endpackage

`default_nettype wire

@@ rtl/core/advd_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module advd_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/advd_div.sv @@
// Restoring divider, one quotient bit per cycle: blocks per row = width / block.
// Depends on advd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module advd_div
   import advd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIM_W-1:0] dividend,
   input  wire logic [BLK_W-1:0] divisor,
   output logic                  busy,
   output logic      [DIM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0] quo_ff, quo_in;
   logic [BLK_W-1:0] rem_ff, rem_in;
   logic [BLK_W-1:0] dvs_ff, dvs_in;
   logic [BLK_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIM_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift the next dividend bit in, subtract when it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = BLK_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BLK_W-1:0];
            quo_in = {quo_ff[DIM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/advd_seq.sv @@
// Decoder sequencer: stream parsing, per-channel delta levels, pixel index and
// last-pixel store accesses over a shared multiplier. Depends on advd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module advd_seq
   import advd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                start,
   input  wire logic                sbit,
   output logic                     busy,
   output store_req_type            store_req,
   input  wire logic [PIX_W-1:0]    store_rdata,
   output logic                     res_offer,
   input  wire logic                res_take,
   output res_type                  res
);

   seq_state_type    state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [LBC_W-1:0] lbc_ff, lbc_in;
   logic [CI_W-1:0]  ci_ff, ci_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [BC_W-1:0]  bc_ff, bc_in;
   logic [PIB_W-1:0] pib_ff, pib_in;

   logic [CH_W-1:0]  level_ff [NUM_CH];
   logic [CH_W-1:0]  level_in [NUM_CH];
   logic [CH_W-1:0]  prev_ff [NUM_CH];
   logic [CH_W-1:0]  prev_in [NUM_CH];
   logic             dir_ff [NUM_CH];
   logic             dir_in [NUM_CH];
   logic [RUN_W-1:0] run_ff [NUM_CH];
   logic [RUN_W-1:0] run_in [NUM_CH];

   logic              bit_ff, bit_in;
   logic [MUL_W-1:0]  sq_ff, sq_in;
   logic [PIX_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0] idx_ff, idx_in;
   res_type           res_ff, res_in;

   logic [1:0]        nch;
   logic [CI_W-1:0]   ch, lch;
   logic [RUN_W-1:0]  run_new;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] step;
   logic [PROD_W-1:0] lvl_sum;
   logic [CH_W-1:0]   lvl_new;
   logic [PROD_W-1:0] addr_sum;
   logic [PROD_W-1:0] idx_sum;
   logic [CH_W:0]     avg_sum [NUM_CH];
   logic [PIX_W-1:0]  acc;
   logic [BC_W:0]     bc_inc;
   logic [ROW_W:0]    row_inc;
   logic              row_wrap, frame_wrap;
   logic [BC_W-1:0]   be_bc;
   logic [ROW_W-1:0]  be_row;
   logic [PIB_W:0]    pib_inc;
   logic [LBC_W:0]    lbc_inc;
   logic [CI_W:0]     ci_inc;

   assign nch = cfg.color_mode ? NCH_RGB : NCH_GRAY;
   assign ch  = (ci_ff > LAST_CH) ? LAST_CH : ci_ff;
   assign lch = (lbc_ff[3:2] > LAST_CH) ? LAST_CH : lbc_ff[3:2];

   // Run length for the bit being decoded
   always_comb begin
      if (bit_ff) begin
         run_new = !dir_ff[ch] ? '0 :
                   (run_ff[ch] == RUN_MAX) ? RUN_MAX : run_ff[ch] + 1'b1;
      end else begin
         run_new = dir_ff[ch] ? '0 :
                   (run_ff[ch] == RUN_MAX) ? RUN_MAX : run_ff[ch] + 1'b1;
      end
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RD, ST_WR: begin
            mul_a = MUL_W'(row_ff);
            mul_b = MUL_W'(cfg.blocks_per_row);
         end
         ST_SQ: begin
            mul_a = MUL_W'(run_new);
            mul_b = MUL_W'(run_new);
         end
         ST_STEP: begin
            mul_a = MUL_W'(bit_ff ? cfg.down_quad : cfg.up_quad);
            mul_b = sq_ff;
         end
         ST_PIX: begin
            mul_a = MUL_W'(row_ff);
            mul_b = MUL_W'(cfg.width);
         end
         ST_IDX: begin
            mul_a = MUL_W'(bc_ff);
            mul_b = MUL_W'(cfg.block);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Level step and clamp
   assign step    = prod + PROD_W'(bit_ff ? cfg.down_base : cfg.up_base);
   assign lvl_sum = step + PROD_W'(level_ff[ch]);
   always_comb begin
      if (bit_ff) begin
         lvl_new = (step >= PROD_W'(level_ff[ch])) ? '0 : level_ff[ch] - step[CH_W-1:0];
      end else begin
         lvl_new = (lvl_sum > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl_sum[CH_W-1:0];
      end
   end

   // Pixel average over the active channels
   always_comb begin
      acc = '0;
      for (int k = 0; k < NUM_CH; k++) begin
         avg_sum[k] = {1'b0, level_ff[k]} + {1'b0, prev_ff[k]};
         if (2'(k) < nch) begin
            acc[k*CH_W +: CH_W] = avg_sum[k][CH_W:1];
         end
      end
   end

   // Block end bookkeeping
   assign bc_inc     = {1'b0, bc_ff} + 1'b1;
   assign row_inc    = {1'b0, row_ff} + 1'b1;
   assign row_wrap   = (BC_W+1)'(bc_inc) >= (BC_W+1)'(cfg.blocks_per_row);
   assign frame_wrap = row_wrap && ((ROW_W+1)'(row_inc) >= (ROW_W+1)'(cfg.height));
   assign be_bc      = row_wrap ? '0 : bc_inc[BC_W-1:0];
   assign be_row     = !row_wrap ? row_ff : (frame_wrap ? '0 : row_inc[ROW_W-1:0]);

   assign addr_sum = (state_ff == ST_RD) ? prod + PROD_W'(bc_ff) - 1'b1
                                         : prod + PROD_W'(bc_ff);
   assign idx_sum  = idx_ff + prod + PROD_W'(pib_ff);
   assign pib_inc  = {1'b0, pib_ff} + 1'b1;
   assign lbc_inc  = {1'b0, lbc_ff} + 1'b1;
   assign ci_inc   = {1'b0, ci_ff} + 1'b1;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      lbc_in    = lbc_ff;
      ci_in     = ci_ff;
      row_in    = row_ff;
      bc_in     = bc_ff;
      pib_in    = pib_ff;
      level_in  = level_ff;
      prev_in   = prev_ff;
      dir_in    = dir_ff;
      run_in    = run_ff;
      bit_in    = bit_ff;
      sq_in     = sq_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      res_in    = res_ff;
      store_req = '0;
      res_offer = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (phase_ff)
                  PH_LEVEL: begin
                     if (sbit) begin
                        level_in[lch][LEVEL_TOP_BIT - {1'b0, lbc_ff[1:0]}] = 1'b1;
                     end
                     if (lbc_inc >= (LBC_W+1)'({nch, 2'b00})) begin
                        phase_in = PH_PIXEL;
                        lbc_in   = '0;
                     end else begin
                        lbc_in = lbc_inc[LBC_W-1:0];
                     end
                  end
                  PH_PIXEL: begin
                     bit_in   = sbit;
                     state_in = ST_SQ;
                  end
                  default: begin
                     if (sbit && bc_ff != '0) begin
                        // fetch the last pixel of the block to the left
                        state_in = ST_RD;
                     end else if (sbit) begin
                        for (int k = 0; k < NUM_CH; k++) begin
                           prev_in[k]  = '0;
                           level_in[k] = '0;
                           dir_in[k]   = 1'b0;
                           run_in[k]   = '0;
                        end
                        lbc_in   = '0;
                        ci_in    = '0;
                        pib_in   = '0;
                        phase_in = PH_LEVEL;
                     end else begin
                        // skipped block
                        phase_in = PH_FLAG;
                        pib_in   = '0;
                        bc_in    = be_bc;
                        row_in   = be_row;
                        if (frame_wrap) begin
                           res_in.pixel_valid = 1'b0;
                           res_in.pixel_index = '0;
                           res_in.pixel_value = '0;
                           res_in.frame_done  = 1'b1;
                           state_in           = ST_EMIT;
                        end
                     end
                  end
               endcase
            end
         end
         ST_RD: begin
            store_req.re    = 1'b1;
            store_req.raddr = addr_sum[STORE_AW-1:0];
            state_in        = ST_RDW;
         end
         ST_RDW: begin
            for (int k = 0; k < NUM_CH; k++) begin
               prev_in[k]  = store_rdata[k*CH_W +: CH_W];
               level_in[k] = '0;
               dir_in[k]   = 1'b0;
               run_in[k]   = '0;
            end
            lbc_in   = '0;
            ci_in    = '0;
            pib_in   = '0;
            phase_in = PH_LEVEL;
            state_in = ST_IDLE;
         end
         ST_SQ: begin
            run_in[ch] = run_new;
            dir_in[ch] = bit_ff;
            sq_in      = prod[MUL_W-1:0];
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            level_in[ch] = lvl_new;
            if (ci_inc >= (CI_W+1)'(nch)) begin
               ci_in    = '0;
               state_in = ST_PIX;
            end else begin
               ci_in    = ci_inc[CI_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_PIX: begin
            for (int k = 0; k < NUM_CH; k++) begin
               if (2'(k) < nch) begin
                  prev_in[k] = level_ff[k];
               end
            end
            acc_in   = acc;
            idx_in   = prod;
            state_in = ST_IDX;
         end
         ST_IDX: begin
            res_in.pixel_valid = 1'b1;
            res_in.pixel_index = idx_sum[INDEX_W-1:0];
            res_in.pixel_value = acc_ff;
            res_in.frame_done  = 1'b0;
            if (pib_inc >= (PIB_W+1)'(cfg.block)) begin
               state_in = ST_WR;
            end else begin
               pib_in   = pib_inc[PIB_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_WR: begin
            // save the block's last pixel, then advance to the next block
            store_req.we      = 1'b1;
            store_req.waddr   = addr_sum[STORE_AW-1:0];
            store_req.wdata   = acc_ff;
            phase_in          = PH_FLAG;
            pib_in            = '0;
            bc_in             = be_bc;
            row_in            = be_row;
            res_in.frame_done = frame_wrap;
            state_in          = ST_EMIT;
         end
         ST_EMIT: begin
            res_offer = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FLAG;
         lbc_ff   <= '0;
         ci_ff    <= '0;
         row_ff   <= '0;
         bc_ff    <= '0;
         pib_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         lbc_ff   <= lbc_in;
         ci_ff    <= ci_in;
         row_ff   <= row_in;
         bc_ff    <= bc_in;
         pib_ff   <= pib_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      prev_ff  <= prev_in;
      dir_ff   <= dir_in;
      run_ff   <= run_in;
      bit_ff   <= bit_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      res_ff   <= res_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign res  = res_ff;

endmodule

`default_nettype wire

@@ rtl/core/adaptive_delta_video_decoder.sv @@
// Adaptive delta video decoder: configuration registers, store clearing,
// output register. Uses advd_pkg, advd_ram, advd_div and advd_seq.
//
// Usage: the req channel carries one compressed stream bit per item; the rsp
// channel returns pixel writes (index, 24-bit value) and frame-done marks.
// Registers are written through csr_write_enable / csr_index / csr_write_data
// while the decoder is idle; req_stall is held high during a write.
// A start level bit, a set flag at a row start and a skip flag that does not
// end the frame are handled in the idle state; a set flag with a left neighbor
// makes one read of the last-pixel store; a pixel bit that is not the last
// channel of a pixel takes the run square, then the step multiply on the shared
// multiplier; the last channel bit of a pixel adds the index multiplies, and a
// block end also the store write; a skip flag that ends the frame emits a
// frame-done mark. After reset the block stalls its input while it clears the
// last-pixel store, and after reset and after every register write while the
// blocks-per-row divider runs. The output register holds a result while
// rsp_stall is high; the next item is still accepted, and decoding waits only
// when a second result is ready before the first has been taken.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_delta_video_decoder
   import advd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_stream_bit,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_pixel_valid,
   output logic      [INDEX_W-1:0]   rsp_pixel_index,
   output logic      [PIX_W-1:0]     rsp_pixel_value,
   output logic                      rsp_frame_done,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);

   logic              color_mode_ff;
   logic [DIM_W-1:0]  frame_width_ff;
   logic [DIM_W-1:0]  frame_height_ff;
   logic [BLK_W-1:0]  block_width_ff;
   logic [STEP_W-1:0] down_base_ff;
   logic [STEP_W-1:0] down_quad_ff;
   logic [STEP_W-1:0] up_base_ff;
   logic [STEP_W-1:0] up_quad_ff;

   logic                clr_active_ff, clr_active_in;
   logic [STORE_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                div_req_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_res_ff;

   cfg_type             cfg;
   logic [DIM_W-1:0]    width_c, height_c;
   logic [BLK_W-1:0]    block_lim;
   logic [DIM_W-1:0]    bpr;
   logic                div_busy;
   logic                seq_busy;
   logic                seq_start;
   store_req_type       store_req;
   logic [PIX_W-1:0]    store_rdata;
   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr;
   logic [PIX_W-1:0]    ram_wdata;
   logic                res_offer;
   logic                res_take;
   res_type             res;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff   <= 1'b0;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         block_width_ff  <= BLOCK_WIDTH_RST;
         down_base_ff    <= STEP_RST;
         down_quad_ff    <= STEP_RST;
         up_base_ff      <= STEP_RST;
         up_quad_ff      <= STEP_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COLOR_MODE:     color_mode_ff   <= csr_write_data[0];
            CSR_FRAME_WIDTH:    frame_width_ff  <= csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   frame_height_ff <= csr_write_data[DIM_W-1:0];
            CSR_BLOCK_WIDTH:    block_width_ff  <= csr_write_data[BLK_W-1:0];
            CSR_DOWN_STEP_BASE: down_base_ff    <= csr_write_data[STEP_W-1:0];
            CSR_DOWN_STEP_QUAD: down_quad_ff    <= csr_write_data[STEP_W-1:0];
            CSR_UP_STEP_BASE:   up_base_ff      <= csr_write_data[STEP_W-1:0];
            CSR_UP_STEP_QUAD:   up_quad_ff      <= csr_write_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp frame geometry
   always_comb begin
      if (frame_width_ff == '0) begin
         width_c = DIM_W'(1);
      end else if (frame_width_ff > DIM_W'(MAX_WIDTH)) begin
         width_c = DIM_W'(MAX_WIDTH);
      end else begin
         width_c = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_c = DIM_W'(1);
      end else if (frame_height_ff > DIM_W'(MAX_HEIGHT)) begin
         height_c = DIM_W'(MAX_HEIGHT);
      end else begin
         height_c = frame_height_ff;
      end
      if (block_width_ff == '0) begin
         block_lim = BLK_W'(1);
      end else if (block_width_ff > BLK_W'(MAX_BLOCK)) begin
         block_lim = BLK_W'(MAX_BLOCK);
      end else begin
         block_lim = block_width_ff;
      end
      if (DIM_W'(block_lim) > width_c) begin
         block_lim = width_c[BLK_W-1:0];
      end
   end

   always_comb begin
      cfg.color_mode     = color_mode_ff;
      cfg.width          = width_c;
      cfg.height         = height_c;
      cfg.block          = block_lim;
      cfg.blocks_per_row = bpr;
      cfg.down_base      = down_base_ff;
      cfg.down_quad      = down_quad_ff;
      cfg.up_base        = up_base_ff;
      cfg.up_quad        = up_quad_ff;
   end

   // Recompute blocks per row after reset and after each register write
   always_ff @(posedge clock) begin
      if (reset) begin
         div_req_ff <= 1'b1;
      end else begin
         div_req_ff <= csr_write_enable;
      end
   end

   advd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_req_ff),
      .dividend (width_c),
      .divisor  (block_lim),
      .busy     (div_busy),
      .quotient (bpr)
   );

   // Clearing pass over the last-pixel store
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   assign ram_we    = clr_active_ff | store_req.we;
   assign ram_waddr = clr_active_ff ? clr_addr_ff : store_req.waddr;
   assign ram_wdata = clr_active_ff ? '0 : store_req.wdata;

   advd_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (PIX_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (store_req.re),
      .raddr (store_req.raddr),
      .rdata (store_rdata)
   );

   assign req_stall = seq_busy | clr_active_ff | div_req_ff | div_busy | csr_write_enable;
   assign seq_start = req_valid & ~req_stall;

   advd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .start       (seq_start),
      .sbit        (req_stream_bit),
      .busy        (seq_busy),
      .store_req   (store_req),
      .store_rdata (store_rdata),
      .res_offer   (res_offer),
      .res_take    (res_take),
      .res         (res)
   );

   // Output register: load when empty or draining this cycle
   assign res_take = res_offer & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_valid = rsp_res_ff.pixel_valid;
   assign rsp_pixel_index = rsp_res_ff.pixel_index;
   assign rsp_pixel_value = rsp_res_ff.pixel_value;
   assign rsp_frame_done  = rsp_res_ff.frame_done;

endmodule

`default_nettype wire
